@@ sv/elementwise_complex_vector_alu_macros.svh @@
// ----------------------------------------------------------------------------
// elementwise complex vector alu assertion macros
// concurrent assertion wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ELEMENTWISE_COMPLEX_VECTOR_ALU_MACROS_SVH
`define ELEMENTWISE_COMPLEX_VECTOR_ALU_MACROS_SVH
`ifndef SYNTHESIS
// checked property, switched off while reset is applied
`define ECVA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked property, also live during reset
`define ECVA_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ECVA_ASSERT(lbl, clk, rstn, prop, msg)
`define ECVA_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

@@ sv/ecva_pkg.sv @@
// ----------------------------------------------------------------------------
// ecva_pkg
// shared widths, codes and pipeline payload types
// ----------------------------------------------------------------------------
package ecva_pkg;

  localparam int DATA_W        = 32;
  localparam int PROD_W        = 64;
  localparam int SUM_W         = 65;
  localparam int MAG_W         = 64;
  localparam int QUO_W         = 32;
  localparam int REM_W         = MAG_W + QUO_W;
  localparam int CFG_IDX_W     = 2;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [DATA_W-1:0] SCALE_RST = 32'h0001_0000;
  localparam logic [DATA_W-1:0] POS_MAX   = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_MAX   = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOMAIN = 2'd0,
    REG_SCALE  = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              ovf;
  } sat_t;

  typedef struct packed {
    op_e  op;
    logic cplx;
    logic last;
    logic ar_pos;
    logic ar_neg;
  } meta_t;

  typedef struct packed {
    meta_t                    meta;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [PROD_W-1:0] p_rr;
    logic signed [PROD_W-1:0] p_ii;
    logic signed [PROD_W-1:0] p_ri;
    logic signed [PROD_W-1:0] p_ir;
    logic signed [PROD_W-1:0] p_x;
    logic signed [PROD_W-1:0] p_y;
  } prod_t;

  typedef struct packed {
    meta_t             meta;
    sat_t              res_re;
    sat_t              res_im;
    logic              neg_re;
    logic              neg_im;
    logic              dz;
    logic [MAG_W-1:0]  mag_re;
    logic [MAG_W-1:0]  mag_im;
    logic [MAG_W-1:0]  den;
  } quo_in_t;

  typedef struct packed {
    meta_t             meta;
    sat_t              res_re;
    sat_t              res_im;
    logic              neg_re;
    logic              neg_im;
    logic              cap_re;
    logic              cap_im;
    logic              dz;
    logic [QUO_W-1:0]  q_re;
    logic [QUO_W-1:0]  q_im;
  } quo_out_t;

endpackage

@@ sv/ecva_in_if.sv @@
// ----------------------------------------------------------------------------
// ecva_in_if
// operand channel: op code, element pair and end of vector mark
// ----------------------------------------------------------------------------
interface ecva_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        op;
  logic signed [ecva_pkg::DATA_W-1:0] a_re;
  logic signed [ecva_pkg::DATA_W-1:0] a_im;
  logic signed [ecva_pkg::DATA_W-1:0] b_re;
  logic signed [ecva_pkg::DATA_W-1:0] b_im;
  logic                              last_in;

  modport source (output valid, op, a_re, a_im, b_re, b_im, last_in, input ready);
  modport sink   (input valid, op, a_re, a_im, b_re, b_im, last_in, output ready);
endinterface

@@ sv/ecva_out_if.sv @@
// ----------------------------------------------------------------------------
// ecva_out_if
// result channel: result element, flags and end of vector mark
// ----------------------------------------------------------------------------
interface ecva_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ecva_pkg::DATA_W-1:0] r_re;
  logic signed [ecva_pkg::DATA_W-1:0] r_im;
  logic                              overflow;
  logic                              div_by_zero;
  logic                              last_out;

  modport source (output valid, r_re, r_im, overflow, div_by_zero, last_out, input ready);
  modport sink   (input valid, r_re, r_im, overflow, div_by_zero, last_out, output ready);
endinterface

@@ sv/ecva_mult.sv @@
// ----------------------------------------------------------------------------
// ecva_mult
// first stage: operand selection and the six 32x32 products
// ----------------------------------------------------------------------------
module ecva_mult (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  logic                               valid_i,
  input  logic [1:0]                         op_i,
  input  logic signed [ecva_pkg::DATA_W-1:0] a_re_i,
  input  logic signed [ecva_pkg::DATA_W-1:0] a_im_i,
  input  logic signed [ecva_pkg::DATA_W-1:0] b_re_i,
  input  logic signed [ecva_pkg::DATA_W-1:0] b_im_i,
  input  logic                               last_i,
  input  logic                               cplx_i,
  input  logic signed [ecva_pkg::DATA_W-1:0] scale_i,
  output logic                               valid_o,
  output ecva_pkg::prod_t                    data_o
);

  localparam int PW = ecva_pkg::PROD_W;

  ecva_pkg::op_e                     op;
  logic                              addsub;
  logic signed [ecva_pkg::DATA_W-1:0] ai, bi, xm, ym;
  ecva_pkg::prod_t                   prod_d, prod_q;
  logic                              valid_q;

  assign op     = ecva_pkg::op_e'(op_i);
  assign addsub = (op == ecva_pkg::OP_ADD) || (op == ecva_pkg::OP_SUB);
  // imaginary parts drop out in the time domain
  assign ai     = cplx_i ? a_im_i : '0;
  assign bi     = cplx_i ? b_im_i : '0;
  // scaled terms for add/sub, squares of b for the divisor otherwise
  assign xm     = addsub ? scale_i : b_re_i;
  assign ym     = addsub ? scale_i : bi;

  always_comb begin
    prod_d.meta.op     = op;
    prod_d.meta.cplx   = cplx_i;
    prod_d.meta.last   = last_i;
    prod_d.meta.ar_pos = !a_re_i[ecva_pkg::DATA_W-1] && (a_re_i != '0);
    prod_d.meta.ar_neg = a_re_i[ecva_pkg::DATA_W-1];
    prod_d.a_re        = a_re_i;
    prod_d.a_im        = ai;
    prod_d.p_rr        = PW'(a_re_i) * PW'(b_re_i);
    prod_d.p_ii        = PW'(ai) * PW'(bi);
    prod_d.p_ri        = PW'(a_re_i) * PW'(bi);
    prod_d.p_ir        = PW'(ai) * PW'(b_re_i);
    prod_d.p_x         = PW'(b_re_i) * PW'(xm);
    prod_d.p_y         = PW'(bi) * PW'(ym);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = prod_q;

endmodule

@@ sv/ecva_prep.sv @@
// ----------------------------------------------------------------------------
// ecva_prep
// product sums, magnitudes, rounding and saturation; divider operands
// ----------------------------------------------------------------------------
module ecva_prep #(
  parameter int FRAC_BITS = ecva_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  ecva_pkg::prod_t   data_i,
  output logic              valid_o,
  output ecva_pkg::quo_in_t data_o
);

  localparam int SW = ecva_pkg::SUM_W;
  localparam int MW = ecva_pkg::MAG_W;
  localparam int DW = ecva_pkg::DATA_W;
  localparam int VW = SW + 1;
  localparam logic [SW-1:0]        HALF   = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [VW-1:0] SAT_HI = VW'(signed'(ecva_pkg::POS_MAX));
  localparam logic signed [VW-1:0] SAT_LO = VW'(signed'(ecva_pkg::NEG_MAX));

  typedef struct packed {
    ecva_pkg::meta_t     meta;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [SW-1:0] v_re;
    logic signed [SW-1:0] v_im;
    logic [MW-1:0]        den;
  } sa_t;

  typedef struct packed {
    ecva_pkg::meta_t     meta;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic                 neg_re;
    logic                 neg_im;
    logic                 dz;
    logic [MW-1:0]        mag_re;
    logic [MW-1:0]        mag_im;
    logic [MW-1:0]        den;
  } sb_t;

  typedef struct packed {
    sb_t           b;
    logic [MW-1:0] rm_re;
    logic [MW-1:0] rm_im;
  } sr_t;

  typedef struct packed {
    sb_t                  b;
    logic signed [VW-1:0] sv_re;
    logic signed [VW-1:0] sv_im;
  } sf_t;

  function automatic logic signed [SW-1:0] sx(input logic signed [ecva_pkg::PROD_W-1:0] p);
    return SW'(p);
  endfunction

  function automatic logic [MW-1:0] mag_of(input logic signed [SW-1:0] v);
    logic [SW-1:0] u;
    u = v[SW-1] ? (~v + 1'b1) : v;
    return u[MW-1:0];
  endfunction

  // round to nearest, ties away from zero, on the magnitude
  function automatic logic [MW-1:0] rnd(input logic [MW-1:0] m);
    logic [SW-1:0] t;
    t = {1'b0, m} + HALF;
    return MW'(t >> FRAC_BITS);
  endfunction

  function automatic logic signed [VW-1:0] lane_val(input ecva_pkg::op_e op, input logic neg,
                                                    input logic [MW-1:0] rm,
                                                    input logic signed [DW-1:0] a);
    logic signed [VW-1:0] ae, re, v;
    ae = VW'(a);
    re = $signed({2'b00, rm});
    case (op)
      ecva_pkg::OP_ADD: v = neg ? ae - re : ae + re;
      ecva_pkg::OP_SUB: v = neg ? ae + re : ae - re;
      ecva_pkg::OP_MUL: v = neg ? -re : re;
      default:          v = '0;
    endcase
    return v;
  endfunction

  function automatic ecva_pkg::sat_t sat_signed(input logic signed [VW-1:0] v);
    ecva_pkg::sat_t s;
    if (v > SAT_HI) begin
      s.val = ecva_pkg::POS_MAX;
      s.ovf = 1'b1;
    end else if (v < SAT_LO) begin
      s.val = ecva_pkg::NEG_MAX;
      s.ovf = 1'b1;
    end else begin
      s.val = v[DW-1:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

  sa_t               a_d, a_q;
  sb_t               b_d, b_q;
  sr_t               r_d, r_q;
  sf_t               f_d, f_q;
  ecva_pkg::quo_in_t g_d, g_q;
  logic [4:0]        vld_q;

  // sums of products per operation
  always_comb begin
    a_d.meta = data_i.meta;
    a_d.a_re = data_i.a_re;
    a_d.a_im = data_i.a_im;
    a_d.den  = MW'(data_i.p_x) + MW'(data_i.p_y);
    case (data_i.meta.op)
      ecva_pkg::OP_MUL: begin
        a_d.v_re = sx(data_i.p_rr) - sx(data_i.p_ii);
        a_d.v_im = sx(data_i.p_ri) + sx(data_i.p_ir);
      end
      ecva_pkg::OP_DIV: begin
        a_d.v_re = sx(data_i.p_rr) + sx(data_i.p_ii);
        a_d.v_im = sx(data_i.p_ir) - sx(data_i.p_ri);
      end
      default: begin
        a_d.v_re = sx(data_i.p_x);
        a_d.v_im = sx(data_i.p_y);
      end
    endcase
  end

  always_comb begin
    b_d.meta   = a_q.meta;
    b_d.a_re   = a_q.a_re;
    b_d.a_im   = a_q.a_im;
    b_d.neg_re = a_q.v_re[SW-1];
    b_d.neg_im = a_q.v_im[SW-1];
    b_d.mag_re = mag_of(a_q.v_re);
    b_d.mag_im = mag_of(a_q.v_im);
    b_d.den    = a_q.den;
    b_d.dz     = (a_q.den == '0);
  end

  always_comb begin
    r_d.b     = b_q;
    r_d.rm_re = rnd(b_q.mag_re);
    r_d.rm_im = rnd(b_q.mag_im);
  end

  always_comb begin
    f_d.b     = r_q.b;
    f_d.sv_re = lane_val(r_q.b.meta.op, r_q.b.neg_re, r_q.rm_re, r_q.b.a_re);
    f_d.sv_im = lane_val(r_q.b.meta.op, r_q.b.neg_im, r_q.rm_im, r_q.b.a_im);
  end

  always_comb begin
    g_d.meta   = f_q.b.meta;
    g_d.res_re = sat_signed(f_q.sv_re);
    g_d.res_im = sat_signed(f_q.sv_im);
    g_d.neg_re = f_q.b.neg_re;
    g_d.neg_im = f_q.b.neg_im;
    g_d.dz     = f_q.b.dz;
    g_d.mag_re = f_q.b.mag_re;
    g_d.mag_im = f_q.b.mag_im;
    g_d.den    = f_q.b.den;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_q <= a_d;
      b_q <= b_d;
      r_q <= r_d;
      f_q <= f_d;
      g_q <= g_d;
    end
  end

  assign valid_o = vld_q[4];
  assign data_o  = g_q;

endmodule

@@ sv/ecva_div.sv @@
// ----------------------------------------------------------------------------
// ecva_div
// pipelined restoring divider, one quotient bit per stage, two lanes
// ----------------------------------------------------------------------------
module ecva_div #(
  parameter int FRAC_BITS = ecva_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  ecva_pkg::quo_in_t  data_i,
  output logic               valid_o,
  output ecva_pkg::quo_out_t data_o
);

  localparam int QW = ecva_pkg::QUO_W;
  localparam int RW = ecva_pkg::REM_W;

  typedef struct packed {
    ecva_pkg::meta_t     meta;
    ecva_pkg::sat_t      res_re;
    ecva_pkg::sat_t      res_im;
    logic                neg_re;
    logic                neg_im;
    logic                cap_re;
    logic                cap_im;
    logic                dz;
    logic [ecva_pkg::MAG_W-1:0] den;
    logic [RW-1:0]       rem_re;
    logic [RW-1:0]       rem_im;
    logic [QW-1:0]       q_re;
    logic [QW-1:0]       q_im;
  } stg_t;

  function automatic stg_t step(input stg_t s, input int sh);
    logic [RW-1:0] t;
    stg_t          n;
    n = s;
    t = RW'(s.den) << sh;
    if (s.rem_re >= t) begin
      n.rem_re = s.rem_re - t;
      n.q_re   = {s.q_re[QW-2:0], 1'b1};
    end else begin
      n.q_re   = {s.q_re[QW-2:0], 1'b0};
    end
    if (s.rem_im >= t) begin
      n.rem_im = s.rem_im - t;
      n.q_im   = {s.q_im[QW-2:0], 1'b1};
    end else begin
      n.q_im   = {s.q_im[QW-2:0], 1'b0};
    end
    return n;
  endfunction

  stg_t          s0_d;
  stg_t          stg_q [QW+1];
  logic          vld_q [QW+1];
  logic [RW-1:0] den_top;

  // quotient needs more than QW bits when n*2^F >= d*2^QW: capped
  assign den_top = RW'(data_i.den) << QW;

  always_comb begin
    s0_d.meta   = data_i.meta;
    s0_d.res_re = data_i.res_re;
    s0_d.res_im = data_i.res_im;
    s0_d.neg_re = data_i.neg_re;
    s0_d.neg_im = data_i.neg_im;
    s0_d.dz     = data_i.dz;
    s0_d.den    = data_i.den;
    s0_d.rem_re = RW'(data_i.mag_re) << FRAC_BITS;
    s0_d.rem_im = RW'(data_i.mag_im) << FRAC_BITS;
    s0_d.cap_re = (s0_d.rem_re >= den_top);
    s0_d.cap_im = (s0_d.rem_im >= den_top);
    s0_d.q_re   = '0;
    s0_d.q_im   = '0;
  end

  for (genvar k = 0; k <= QW; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (adv_i) begin
          vld_q[k] <= valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          stg_q[k] <= s0_d;
        end
      end
    end else begin : g_bit
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (adv_i) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          stg_q[k] <= step(stg_q[k-1], QW - k);
        end
      end
    end
  end

  assign valid_o       = vld_q[QW];
  assign data_o.meta   = stg_q[QW].meta;
  assign data_o.res_re = stg_q[QW].res_re;
  assign data_o.res_im = stg_q[QW].res_im;
  assign data_o.neg_re = stg_q[QW].neg_re;
  assign data_o.neg_im = stg_q[QW].neg_im;
  assign data_o.cap_re = stg_q[QW].cap_re;
  assign data_o.cap_im = stg_q[QW].cap_im;
  assign data_o.dz     = stg_q[QW].dz;
  assign data_o.q_re   = stg_q[QW].q_re;
  assign data_o.q_im   = stg_q[QW].q_im;

endmodule

@@ sv/elementwise_complex_vector_alu.sv @@
// ----------------------------------------------------------------------------
// elementwise_complex_vector_alu
// element-wise scaled add, scaled subtract, multiply and divide, Q16.16
// ----------------------------------------------------------------------------
//  channel   dir   transfer when          payload
//  in_if     in    valid & ready          op, a_re, a_im, b_re, b_im, last_in
//  out_if    out   valid & ready          r_re, r_im, overflow, div_by_zero, last_out
//  cfg       in    cfg_we_i               cfg_idx_i, cfg_wdata_i
//
//  one item per cycle while the output is not stalled; the pipe holds a product
//  stage, five combine stages, the divider's range stage and 32 quotient bit stages
//  (one restoring step each), and the output register
//  every item runs the full pipe so results leave in order
//  a stalled output freezes every stage; ready falls only then
//  reset clears the valid bits and the configuration registers; nothing needs a sweep
// ----------------------------------------------------------------------------
`include "elementwise_complex_vector_alu_macros.svh"

module elementwise_complex_vector_alu #(
  parameter int FRAC_BITS = ecva_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ecva_in_if.sink                           in_if,
  ecva_out_if.source                        out_if,
  input  logic                              cfg_we_i,
  input  logic [ecva_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ecva_pkg::DATA_W-1:0]       cfg_wdata_i
);

  localparam int DW = ecva_pkg::DATA_W;
  localparam int QW = ecva_pkg::QUO_W;

  // configuration registers
  logic          domain_q;
  logic [DW-1:0] scale_q;

  // pipeline links
  logic               adv;
  logic               mv, pv, dv;
  ecva_pkg::prod_t    md;
  ecva_pkg::quo_in_t  pd;
  ecva_pkg::quo_out_t dd;

  // output register
  logic          out_valid_q;
  logic [DW-1:0] r_re_q, r_im_q, r_re_d, r_im_d;
  logic          overflow_q, div_by_zero_q, last_out_q;
  logic          overflow_d, div_by_zero_d;

  // whole pipe moves unless a finished result is held back
  assign adv         = !out_valid_q || out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      domain_q <= 1'b0;
      scale_q  <= ecva_pkg::SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (ecva_pkg::cfg_reg_e'(cfg_idx_i))
        ecva_pkg::REG_DOMAIN: domain_q <= cfg_wdata_i[0];
        ecva_pkg::REG_SCALE:  scale_q  <= cfg_wdata_i;
        default: ;  // writes to unmapped indexes are dropped
      endcase
    end
  end

  ecva_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_if.valid),
    .op_i    (in_if.op),
    .a_re_i  (in_if.a_re),
    .a_im_i  (in_if.a_im),
    .b_re_i  (in_if.b_re),
    .b_im_i  (in_if.b_im),
    .last_i  (in_if.last_in),
    .cplx_i  (domain_q),
    .scale_i (signed'(scale_q)),
    .valid_o (mv),
    .data_o  (md)
  );

  ecva_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (mv),
    .data_i  (md),
    .valid_o (pv),
    .data_o  (pd)
  );

  ecva_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (pv),
    .data_i  (pd),
    .valid_o (dv),
    .data_o  (dd)
  );

  // saturate an unsigned quotient magnitude with its sign
  function automatic ecva_pkg::sat_t sat_mag(input logic neg, input logic [QW:0] m);
    ecva_pkg::sat_t s;
    logic [QW:0]    n;
    n = ~m + 1'b1;
    if (!neg) begin
      s.ovf = (m > {1'b0, ecva_pkg::POS_MAX});
      s.val = s.ovf ? ecva_pkg::POS_MAX : m[DW-1:0];
    end else begin
      s.ovf = (m > {1'b0, ecva_pkg::NEG_MAX});
      s.val = s.ovf ? ecva_pkg::NEG_MAX : n[DW-1:0];
    end
    return s;
  endfunction

  ecva_pkg::sat_t qs_re, qs_im;
  logic [QW:0]    qm_re, qm_im;

  // capped quotient reads as 2^32, which always saturates
  assign qm_re = dd.cap_re ? {1'b1, {QW{1'b0}}} : {1'b0, dd.q_re};
  assign qm_im = dd.cap_im ? {1'b1, {QW{1'b0}}} : {1'b0, dd.q_im};
  assign qs_re = sat_mag(dd.neg_re, qm_re);
  assign qs_im = sat_mag(dd.neg_im, qm_im);

  always_comb begin
    div_by_zero_d = 1'b0;
    if (dd.meta.op == ecva_pkg::OP_DIV) begin
      if (dd.dz) begin
        // zero divisor: real quotient takes the numerator's sign, complex gives zero
        div_by_zero_d = 1'b1;
        overflow_d    = 1'b0;
        r_im_d        = '0;
        if (dd.meta.cplx || !(dd.meta.ar_pos || dd.meta.ar_neg)) begin
          r_re_d = '0;
        end else begin
          r_re_d = dd.meta.ar_pos ? ecva_pkg::POS_MAX : ecva_pkg::NEG_MAX;
        end
      end else begin
        r_re_d     = qs_re.val;
        r_im_d     = qs_im.val;
        overflow_d = qs_re.ovf || qs_im.ovf;
      end
    end else begin
      r_re_d     = dd.res_re.val;
      r_im_d     = dd.res_im.val;
      overflow_d = dd.res_re.ovf || dd.res_im.ovf;
    end
    // time domain results carry no imaginary part
    if (!dd.meta.cplx) begin
      r_im_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_re_q        <= r_re_d;
      r_im_q        <= r_im_d;
      overflow_q    <= overflow_d;
      div_by_zero_q <= div_by_zero_d;
      last_out_q    <= dd.meta.last;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.r_re        = signed'(r_re_q);
  assign out_if.r_im        = signed'(r_im_q);
  assign out_if.overflow    = overflow_q;
  assign out_if.div_by_zero = div_by_zero_q;
  assign out_if.last_out    = last_out_q;

  // a result only appears when the divider's last stage held an item
  `ECVA_ASSERT_NR(a_out_from_pipe, clk_i, $rose(out_valid_q) |-> $past(dv), "output valid without item")
  // zero divisor never flags saturation and never leaves an imaginary part
  `ECVA_ASSERT(a_dz_clean, clk_i, rst_ni, out_valid_q && div_by_zero_q |-> !overflow_q && r_im_q == '0, "div by zero result not clean")
  // an out of range quotient must come out saturated
  `ECVA_ASSERT(a_cap_ovf, clk_i, rst_ni, adv && dv && dd.meta.op == ecva_pkg::OP_DIV && !dd.dz && dd.cap_re |=> overflow_q, "capped quotient not flagged")
  // real divide by zero with a positive numerator gives the positive limit
  `ECVA_ASSERT(a_dz_pos, clk_i, rst_ni, adv && dv && dd.meta.op == ecva_pkg::OP_DIV && dd.dz && !dd.meta.cplx && dd.meta.ar_pos |=> r_re_q == ecva_pkg::POS_MAX, "real div by zero limit wrong")

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: elementwise complex vector alu testbench
// drives operand transfers with random gaps, stalls the result side, and
// checks every result against a bit-exact predictor held in a scoreboard
// ----------------------------------------------------------------------------
module tb;

  localparam int FB = ecva_pkg::FRAC_BITS_DEF;
  localparam logic [ecva_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd2;
  localparam int PIPE_SETTLE = 60;

  typedef struct {
    logic [ecva_pkg::DATA_W-1:0] r_re;
    logic [ecva_pkg::DATA_W-1:0] r_im;
    logic                        ovf;
    logic                        dz;
    logic                        last;
  } alu_result_t;

  // scoreboard: predictor state plus the queue of results still to come
  class alu_scoreboard;
    logic                        domain_cplx;
    logic [ecva_pkg::DATA_W-1:0] scale;
    alu_result_t                 result_q[$];
    int                          errors;

    function new();
      domain_cplx = 1'b0;
      scale       = ecva_pkg::SCALE_RST;
      errors      = 0;
    endfunction

    function void write_reg(logic [ecva_pkg::CFG_IDX_W-1:0] idx,
                            logic [ecva_pkg::DATA_W-1:0] val);
      if (idx == ecva_pkg::REG_DOMAIN) domain_cplx = val[0];
      else if (idx == ecva_pkg::REG_SCALE) scale = val;
    endfunction

    function logic [127:0] magn(logic signed [127:0] x);
      return (x < 0) ? -x : x;
    endfunction

    function logic [127:0] rnd_shift(logic [127:0] m);
      return (m + (128'd1 << (FB - 1))) >> FB;
    endfunction

    function logic [ecva_pkg::DATA_W-1:0] sat32(bit neg, logic [127:0] m, inout bit ovf);
      logic [127:0] t;
      if (!neg) begin
        if (m > 128'h7FFF_FFFF) begin
          ovf = 1'b1;
          return ecva_pkg::POS_MAX;
        end
        return m[31:0];
      end
      if (m > 128'h8000_0000) begin
        ovf = 1'b1;
        return ecva_pkg::NEG_MAX;
      end
      t = -m;
      return t[31:0];
    endfunction

    // fixed point quotient of magnitudes, capped just above the 32 bit range
    function logic [127:0] quot(logic [127:0] n, logic [127:0] d);
      logic [127:0] q;
      q = (n << FB) / d;
      return (q > (128'd1 << 32)) ? (128'd1 << 32) : q;
    endfunction

    function logic signed [127:0] scaled_term(logic signed [127:0] b,
                                              logic signed [127:0] s);
      logic signed [127:0] p;
      logic [127:0]        m;
      p = b * s;
      m = rnd_shift(magn(p));
      return (p < 0) ? -$signed(m) : $signed(m);
    endfunction

    function void note_operand(ecva_pkg::op_e op, logic signed [31:0] a_re, a_im, b_re,
                               b_im, logic last);
      logic signed [127:0] ar, ai, br, bi, s, tr, ti, x, y, d;
      alu_result_t         r;
      bit                  ovf, dz;
      ar = a_re; ai = a_im; br = b_re; bi = b_im;
      s  = $signed(scale);
      ovf = 0; dz = 0;
      r.r_re = '0; r.r_im = '0;
      if (!domain_cplx) begin
        ai = 0;
        bi = 0;
      end
      case (op)
        ecva_pkg::OP_ADD, ecva_pkg::OP_SUB: begin
          tr = scaled_term(br, s);
          ti = scaled_term(bi, s);
          x = (op == ecva_pkg::OP_ADD) ? ar + tr : ar - tr;
          y = (op == ecva_pkg::OP_ADD) ? ai + ti : ai - ti;
          r.r_re = sat32(x < 0, magn(x), ovf);
          r.r_im = sat32(y < 0, magn(y), ovf);
        end
        ecva_pkg::OP_MUL: begin
          x = ar * br - ai * bi;
          y = ar * bi + ai * br;
          r.r_re = sat32(x < 0, rnd_shift(magn(x)), ovf);
          r.r_im = sat32(y < 0, rnd_shift(magn(y)), ovf);
        end
        default: begin
          if (!domain_cplx) begin
            if (br == 0) begin
              // real divide by zero: saturate with the numerator's sign
              dz = 1;
              r.r_re = (ar > 0) ? ecva_pkg::POS_MAX : ((ar < 0) ? ecva_pkg::NEG_MAX : '0);
            end else begin
              r.r_re = sat32((ar < 0) != (br < 0), quot(magn(ar), magn(br)), ovf);
            end
          end else begin
            d = br * br + bi * bi;
            if (d == 0) begin
              dz = 1;
            end else begin
              x = ar * br + ai * bi;
              y = ai * br - ar * bi;
              r.r_re = sat32(x < 0, quot(magn(x), d), ovf);
              r.r_im = sat32(y < 0, quot(magn(y), d), ovf);
            end
          end
        end
      endcase
      if (!domain_cplx) r.r_im = '0;
      r.ovf  = ovf;
      r.dz   = dz;
      r.last = last;
      result_q.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_result(alu_result_t got);
      alu_result_t want;
      if (result_q.size() == 0) begin
        report("unexpected result", got.r_re, '0);
        return;
      end
      want = result_q.pop_front();
      if (got.r_re !== want.r_re) report("r_re", got.r_re, want.r_re);
      if (got.r_im !== want.r_im) report("r_im", got.r_im, want.r_im);
      if (got.ovf !== want.ovf) report("overflow", got.ovf, want.ovf);
      if (got.dz !== want.dz) report("div_by_zero", got.dz, want.dz);
      if (got.last !== want.last) report("last_out", got.last, want.last);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ecva_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [ecva_pkg::DATA_W-1:0]    cfg_wdata;

  ecva_in_if  in_ch ();
  ecva_out_if out_ch ();

  alu_scoreboard sb = new();

  bit idle_en = 1'b1;    // random gaps on both sides
  int hold_req = 0;      // long result side hold-off, in cycles
  int stall_left = 0;

  elementwise_complex_vector_alu u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stall bursts and the odd long hold-off
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (hold_req > 0) begin
      stall_left = hold_req - 1;
      hold_req = 0;
      out_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result monitor: values seen here are those present at the edge
  always @(posedge clk) begin
    alu_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.r_re = out_ch.r_re;
      got.r_im = out_ch.r_im;
      got.ovf  = out_ch.overflow;
      got.dz   = out_ch.div_by_zero;
      got.last = out_ch.last_out;
      sb.check_result(got);
    end
  end

  // one operand transfer, with an optional random gap ahead of it
  task send_item(ecva_pkg::op_e op, logic [31:0] ar, ai, br, bi, logic last);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.a_re    <= ar;
    in_ch.a_im    <= ai;
    in_ch.b_re    <= br;
    in_ch.b_im    <= bi;
    in_ch.last_in <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_operand(op, ar, ai, br, bi, last);
  endtask

  task wait_drain();
    while (sb.result_q.size() > 0) @(posedge clk);
  endtask

  // registers change only with the pipe empty
  task write_reg(logic [ecva_pkg::CFG_IDX_W-1:0] idx, logic [ecva_pkg::DATA_W-1:0] val);
    in_ch.valid <= 1'b0;
    wait_drain();
    repeat (PIPE_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 9))
      0: return ecva_pkg::POS_MAX;
      1: return ecva_pkg::NEG_MAX;
      2: return '0;
      3: return ($urandom_range(0, 1)) ? 32'h0001_0000 : 32'hFFFF_0000;
      4: return ($urandom_range(0, 1)) ? 32'd1 : 32'hFFFF_FFFF;
      5, 6: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  task send_random(int n);
    logic [31:0] br, bi;
    repeat (n) begin
      br = rand_val();
      bi = rand_val();
      // both divisor parts zero now and then for the complex zero divide
      if ($urandom_range(0, 9) == 0) begin
        br = '0;
        bi = '0;
      end
      send_item(ecva_pkg::op_e'($urandom_range(0, 3)), rand_val(), rand_val(), br, bi,
                $urandom_range(0, 7) == 0);
    end
  endtask

  task send_directed();
    send_item(ecva_pkg::OP_ADD, ecva_pkg::POS_MAX, ecva_pkg::POS_MAX,
              ecva_pkg::POS_MAX, ecva_pkg::POS_MAX, 1'b0);
    send_item(ecva_pkg::OP_ADD, ecva_pkg::NEG_MAX, ecva_pkg::NEG_MAX,
              ecva_pkg::NEG_MAX, ecva_pkg::NEG_MAX, 1'b0);
    send_item(ecva_pkg::OP_SUB, ecva_pkg::NEG_MAX, 32'd5, ecva_pkg::POS_MAX, 32'd7, 1'b0);
    send_item(ecva_pkg::OP_SUB, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
    send_item(ecva_pkg::OP_MUL, ecva_pkg::POS_MAX, ecva_pkg::NEG_MAX,
              ecva_pkg::POS_MAX, ecva_pkg::NEG_MAX, 1'b0);
    send_item(ecva_pkg::OP_MUL, ecva_pkg::NEG_MAX, ecva_pkg::NEG_MAX,
              ecva_pkg::NEG_MAX, ecva_pkg::NEG_MAX, 1'b0);
    send_item(ecva_pkg::OP_MUL, 32'h0000_8000, 32'hFFFF_8000, 32'd1, 32'd1, 1'b0);
    send_item(ecva_pkg::OP_DIV, 32'h0001_0000, 32'd3, 32'd0, 32'd0, 1'b0);
    send_item(ecva_pkg::OP_DIV, ecva_pkg::NEG_MAX, 32'd3, 32'd0, 32'd0, 1'b0);
    send_item(ecva_pkg::OP_DIV, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    send_item(ecva_pkg::OP_DIV, ecva_pkg::POS_MAX, ecva_pkg::POS_MAX, 32'd1, 32'd0, 1'b0);
    send_item(ecva_pkg::OP_DIV, ecva_pkg::NEG_MAX, ecva_pkg::NEG_MAX, 32'hFFFF_FFFF,
              32'd1, 1'b0);
    send_item(ecva_pkg::OP_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0002_0000,
              32'hFFFF_0000, 1'b1);
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = ecva_pkg::REG_DOMAIN;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.op      = ecva_pkg::OP_ADD;
    in_ch.a_re    = '0;
    in_ch.a_im    = '0;
    in_ch.b_re    = '0;
    in_ch.b_im    = '0;
    in_ch.last_in = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners in both domains, reset scale first
    send_directed();
    write_reg(ecva_pkg::REG_DOMAIN, 32'd1);
    send_directed();

    // random phases over a spread of settings, extremes included
    write_reg(ecva_pkg::REG_SCALE, ecva_pkg::POS_MAX);
    send_random(70);
    write_reg(ecva_pkg::REG_DOMAIN, 32'd0);
    write_reg(ecva_pkg::REG_SCALE, ecva_pkg::NEG_MAX);
    send_random(70);
    write_reg(ecva_pkg::REG_SCALE, 32'd0);
    send_random(60);
    write_reg(CFG_IDX_SPARE, 32'hFFFF_FFFF);   // ignored index
    write_reg(ecva_pkg::REG_SCALE, $urandom);
    send_random(70);

    // long hold-off on the result side while operands keep coming
    write_reg(ecva_pkg::REG_DOMAIN, 32'hFFFF_FFFF);
    idle_en  = 1'b0;
    hold_req = 300;
    send_random(120);
    idle_en = 1'b1;

    // sender pauses until every result is back
    in_ch.valid <= 1'b0;
    wait_drain();
    @(posedge clk);
    write_reg(ecva_pkg::REG_SCALE, 32'hFFFF_0000);
    send_random(80);
    write_reg(ecva_pkg::REG_SCALE, $urandom_range(0, 32'h3_FFFF));
    send_random(80);

    // closing stretch with no idling on either side
    write_reg(ecva_pkg::REG_DOMAIN, 32'd0);
    idle_en = 1'b0;
    send_random(80);
    in_ch.valid <= 1'b0;

    wait_drain();
    repeat (PIPE_SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.result_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+sv
sv/ecva_pkg.sv
sv/ecva_in_if.sv
sv/ecva_out_if.sv
sv/ecva_mult.sv
sv/ecva_prep.sv
sv/ecva_div.sv
sv/elementwise_complex_vector_alu.sv
sim/tb.sv
